@@ sv/gn3_pkg.sv @@
// Package for the 3D gradient noise unit: field widths, item codes,
// gradient table and the hash reduction helper. No dependencies.
package gn3_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned PERM_AW       = 8;
  localparam int unsigned PERM_DEPTH    = 256;
  localparam int unsigned OUT_W         = 19;
  localparam int unsigned OUT_FRAC      = 16;
  localparam int          OUT_MAX       = 262143;
  localparam int          OUT_MIN       = -262144;
  localparam int unsigned NUM_GRAD      = 12;
  localparam int unsigned LOOKUP_STAGES = 5;
  localparam int unsigned BLEND_STAGES  = 5;
  localparam int unsigned NSTG          = LOOKUP_STAGES + BLEND_STAGES;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  typedef logic signed [1:0] grad_t;

  localparam grad_t GRAD [NUM_GRAD][3] = '{
    '{ 2'sd1,  2'sd1,  2'sd0}, '{-2'sd1,  2'sd1,  2'sd0},
    '{ 2'sd1, -2'sd1,  2'sd0}, '{-2'sd1, -2'sd1,  2'sd0},
    '{ 2'sd1,  2'sd0,  2'sd1}, '{-2'sd1,  2'sd0,  2'sd1},
    '{ 2'sd1,  2'sd0, -2'sd1}, '{-2'sd1,  2'sd0, -2'sd1},
    '{ 2'sd0,  2'sd1,  2'sd1}, '{ 2'sd0, -2'sd1,  2'sd1},
    '{ 2'sd0,  2'sd1, -2'sd1}, '{ 2'sd0, -2'sd1, -2'sd1}
  };

  typedef struct packed {
    logic               en;
    logic [PERM_AW-1:0] addr;
    logic [PERM_AW-1:0] data;
  } perm_wr_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [PERM_AW-1:0] idx;
    logic [PERM_AW-1:0] val;
  } item_t;

  // h mod 12 through a reciprocal multiply, exact for 8-bit h
  function automatic logic [3:0] mod12(input logic [7:0] h);
    logic [15:0] p;
    logic [4:0]  q;
    logic [7:0]  r;
    p = 16'(h) * 16'd171;
    q = p[15:11];
    r = h - 8'(q) * 8'd12;
    return r[3:0];
  endfunction

endpackage

@@ sv/gradient_noise_3d_unit.sv @@
// Top level of the 3D gradient noise unit.
// Depends on gn3_pkg, gn3_perm_bank, gn3_fade and gn3_blend.
//
// Input channel (in_valid_i/in_ready_o) takes one item per cycle. kind_i = 1
// evaluates noise at (coord_x_i, coord_y_i, coord_z_i), signed with FracBits
// fraction bits; kind_i = 0 writes entry_value_i into permutation entry
// entry_index_i and gives no result. Writes apply in item order: every later
// evaluation sees the new entry, every earlier one the old.
// Output channel (out_valid_o/out_ready_i) carries noise_value_o, Q2.16,
// saturated.
// Throughput: one item per cycle through a ten-stage pipeline of
// four lookup stages (seven dual-port table copies), one dot stage and five
// blend stages; each multiplier sits between registers.
// Reset: the table reads as identity, the pipeline and output empty; the
// unit accepts items as soon as reset is released.
// Stall: a one-entry skid holds a result the receiver does not take; while
// it is full in_ready_o is low and the whole pipeline holds.
module gradient_noise_3d_unit #(
  parameter int unsigned FracBits = gn3_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  kind_i,
  input  logic signed [gn3_pkg::COORD_W-1:0]    coord_x_i,
  input  logic signed [gn3_pkg::COORD_W-1:0]    coord_y_i,
  input  logic signed [gn3_pkg::COORD_W-1:0]    coord_z_i,
  input  logic [gn3_pkg::PERM_AW-1:0]           entry_index_i,
  input  logic [gn3_pkg::PERM_AW-1:0]           entry_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [gn3_pkg::OUT_W-1:0]      noise_value_o
);
  import gn3_pkg::*;

  localparam int unsigned WV = FracBits + 4;
  localparam logic signed [WV-1:0] ONE = WV'(1) <<< FracBits;

  logic                    en;
  logic [NSTG-1:0]         vld_q, kind_q;
  item_t                   pipe_q [4];
  perm_wr_t                wr_z, wr_y, wr_x;
  logic [1:0][7:0]         z_addr;
  logic [1:0][7:0]         hz;
  logic [1:0][1:0][7:0]    y_addr, hy;
  logic [3:0][1:0][7:0]    x_addr, hx;
  logic [7:0]              z0, y0, x0;
  logic [2:0][FracBits-1:0] t_in;
  logic [2:0][FracBits:0]  fade;
  logic signed [WV-1:0]    fxs, fys, fzs, gxs, gys, gzs;
  logic signed [WV-1:0]    dot_d [8];
  logic signed [WV-1:0]    dot_q [8];
  logic signed [OUT_W-1:0] res;
  logic                    push;
  logic                    out_valid_q, skid_full_q;
  logic signed [OUT_W-1:0] out_q, skid_q;

  function automatic logic signed [WV-1:0] gsel(input grad_t g, input logic signed [WV-1:0] d);
    if (g == 2'sd0) begin
      return '0;
    end
    return g[1] ? -d : d;
  endfunction

  assign en         = !skid_full_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      kind_q <= '0;
    end else if (en) begin
      vld_q  <= {vld_q[NSTG-2:0], in_valid_i};
      kind_q <= {kind_q[NSTG-2:0], kind_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pipe_q[0] <= '{x: coord_x_i, y: coord_y_i, z: coord_z_i,
                     idx: entry_index_i, val: entry_value_i};
      for (int i = 1; i < 4; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  // write each table copy at the stage where it is read
  always_comb begin
    wr_z = '{en: en && vld_q[0] && (kind_q[0] == KIND_WRITE),
             addr: pipe_q[0].idx, data: pipe_q[0].val};
    wr_y = '{en: en && vld_q[1] && (kind_q[1] == KIND_WRITE),
             addr: pipe_q[1].idx, data: pipe_q[1].val};
    wr_x = '{en: en && vld_q[2] && (kind_q[2] == KIND_WRITE),
             addr: pipe_q[2].idx, data: pipe_q[2].val};
  end

  always_comb begin
    z0 = pipe_q[0].z[FracBits +: 8];
    y0 = pipe_q[1].y[FracBits +: 8];
    x0 = pipe_q[2].x[FracBits +: 8];
    z_addr[0] = z0;
    z_addr[1] = z0 + 8'd1;
    for (int j = 0; j < 2; j++) begin
      y_addr[j][0] = y0 + hz[j];
      y_addr[j][1] = y0 + 8'd1 + hz[j];
    end
    for (int k = 0; k < 4; k++) begin
      x_addr[k][0] = x0 + hy[k/2][k%2];
      x_addr[k][1] = x0 + 8'd1 + hy[k/2][k%2];
    end
  end

  gn3_perm_bank u_bank_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .wr_i    (wr_z),
    .raddr_i (z_addr),
    .rdata_o (hz)
  );

  for (genvar j = 0; j < 2; j++) begin : g_bank_y
    gn3_perm_bank u_bank (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .wr_i    (wr_y),
      .raddr_i (y_addr[j]),
      .rdata_o (hy[j])
    );
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank_x
    gn3_perm_bank u_bank (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .wr_i    (wr_x),
      .raddr_i (x_addr[k]),
      .rdata_o (hx[k])
    );
  end

  always_comb begin
    t_in[0] = pipe_q[0].x[FracBits-1:0];
    t_in[1] = pipe_q[0].y[FracBits-1:0];
    t_in[2] = pipe_q[0].z[FracBits-1:0];
  end

  gn3_fade #(.FracBits(FracBits)) u_fade (
    .clk_i  (clk_i),
    .en_i   (en),
    .t_i    (t_in),
    .fade_o (fade)
  );

  always_comb begin
    logic [3:0] h;
    logic signed [WV-1:0] dx, dy, dz;
    fxs = WV'(signed'({1'b0, pipe_q[3].x[FracBits-1:0]}));
    fys = WV'(signed'({1'b0, pipe_q[3].y[FracBits-1:0]}));
    fzs = WV'(signed'({1'b0, pipe_q[3].z[FracBits-1:0]}));
    gxs = fxs - ONE;
    gys = fys - ONE;
    gzs = fzs - ONE;
    for (int c = 0; c < 8; c++) begin
      h  = mod12(hx[c/2][c%2]);
      dx = (c % 2 == 1) ? gxs : fxs;
      dy = ((c / 2) % 2 == 1) ? gys : fys;
      dz = (c / 4 == 1) ? gzs : fzs;
      dot_d[c] = gsel(GRAD[h][0], dx) + gsel(GRAD[h][1], dy) + gsel(GRAD[h][2], dz);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 8; c++) begin
        dot_q[c] <= dot_d[c];
      end
    end
  end

  gn3_blend #(.FracBits(FracBits)) u_blend (
    .clk_i   (clk_i),
    .en_i    (en),
    .dot_i   (dot_q),
    .fade_i  (fade),
    .noise_o (res)
  );

  assign push = en && vld_q[NSTG-1] && (kind_q[NSTG-1] == KIND_EVAL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (out_ready_i) begin
        skid_full_q <= 1'b0;
      end
    end else if (out_valid_q && !out_ready_i) begin
      if (push) begin
        skid_full_q <= 1'b1;
      end
    end else begin
      out_valid_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (out_ready_i) begin
        out_q <= skid_q;
      end
    end else if (out_valid_q && !out_ready_i) begin
      if (push) begin
        skid_q <= res;
      end
    end else begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = out_q;

endmodule

@@ sv/gn3_perm_bank.sv @@
// One copy of the 256-entry permutation table with two registered read ports.
// Reads as identity until an entry is written. Uses gn3_pkg.
module gn3_perm_bank (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  gn3_pkg::perm_wr_t         wr_i,
  input  logic [1:0][7:0]           raddr_i,
  output logic [1:0][7:0]           rdata_o
);
  import gn3_pkg::*;

  logic [PERM_AW-1:0]    mem [PERM_DEPTH];
  logic [PERM_DEPTH-1:0] wvld_q;
  logic [1:0][7:0]       rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvld_q <= '0;
    end else if (wr_i.en) begin
      wvld_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int p = 0; p < 2; p++) begin
        rdata_q[p] <= wvld_q[raddr_i[p]] ? mem[raddr_i[p]] : raddr_i[p];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/gn3_fade.sv @@
// Four-stage quintic fade 6t^5-15t^4+10t^3 for three axes, one multiply per stage.
// Uses gn3_pkg.
module gn3_fade #(
  parameter int unsigned FracBits = gn3_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [2:0][FracBits-1:0]   t_i,
  output logic [2:0][FracBits:0]     fade_o
);
  import gn3_pkg::*;

  localparam int unsigned WB = FracBits + 5;
  localparam int unsigned WP = 2 * FracBits + 7;
  localparam logic signed [WB-1:0] ONE  = WB'(1) <<< FracBits;
  localparam logic signed [WB-1:0] K10  = (ONE <<< 3) + (ONE <<< 1);
  localparam logic signed [WB-1:0] K15  = (ONE <<< 4) - ONE;
  localparam logic signed [WP-1:0] HALF = WP'(1) <<< (FracBits - 1);

  logic signed [WB-1:0] t1_q [3], t2_q [3], t3_q [3];
  logic signed [WB-1:0] b1_q [3], b2_q [3], b3_q [3];
  logic [FracBits:0]    fade_q [3];
  logic signed [WB-1:0] t0 [3], a0 [3];
  logic signed [WP-1:0] p0 [3], p1 [3], p2 [3], p3 [3];
  logic signed [WB-1:0] b4 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t0[i] = WB'(signed'({1'b0, t_i[i]}));
      a0[i] = (t0[i] <<< 2) + (t0[i] <<< 1) - K15;
      p0[i] = WP'(t0[i]) * WP'(a0[i]);
      p1[i] = WP'(t1_q[i]) * WP'(b1_q[i]);
      p2[i] = WP'(t2_q[i]) * WP'(b2_q[i]);
      p3[i] = WP'(t3_q[i]) * WP'(b3_q[i]);
      b4[i] = WB'((p3[i] + HALF) >>> FracBits);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        t1_q[i] <= t0[i];
        b1_q[i] <= WB'((p0[i] + HALF) >>> FracBits) + K10;
        t2_q[i] <= t1_q[i];
        b2_q[i] <= WB'((p1[i] + HALF) >>> FracBits);
        t3_q[i] <= t2_q[i];
        b3_q[i] <= WB'((p2[i] + HALF) >>> FracBits);
        if (b4[i] < 0) begin
          fade_q[i] <= '0;
        end else if (b4[i] > ONE) begin
          fade_q[i] <= ONE[FracBits:0];
        end else begin
          fade_q[i] <= b4[i][FracBits:0];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fade_o[i] = fade_q[i];
    end
  end

endmodule

@@ sv/gn3_blend.sv @@
// Trilinear blend of the eight corner dot products over five register stages,
// then output scaling and saturation. Uses gn3_pkg.
module gn3_blend #(
  parameter int unsigned FracBits = gn3_pkg::FRAC_BITS_DEF,
  localparam int unsigned WV = FracBits + 4
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [WV-1:0]        dot_i [8],
  input  logic [2:0][FracBits:0]      fade_i,
  output logic signed [gn3_pkg::OUT_W-1:0] noise_o
);
  import gn3_pkg::*;

  localparam int unsigned WP  = 2 * FracBits + 7;
  localparam int unsigned WE  = WV + 16;
  localparam int unsigned SHR = (FracBits > OUT_FRAC) ? FracBits - OUT_FRAC : 0;
  localparam int unsigned SHL = (FracBits < OUT_FRAC) ? OUT_FRAC - FracBits : 0;
  localparam logic signed [WP-1:0] HALF   = WP'(1) <<< (FracBits - 1);
  localparam logic signed [WE-1:0] RND    = (WE'(1) <<< SHR) >>> 1;
  localparam logic signed [WE-1:0] SAT_HI = WE'(OUT_MAX);
  localparam logic signed [WE-1:0] SAT_LO = WE'(OUT_MIN);

  logic signed [WP-1:0] px_q [4];
  logic signed [WV-1:0] cx_q [4];
  logic signed [WV-1:0] lx_q [4];
  logic signed [WP-1:0] py_q [2];
  logic signed [WV-1:0] cy_q [2];
  logic signed [WV-1:0] ly_q [2];
  logic signed [WP-1:0] pz_q;
  logic signed [WV-1:0] cz_q;
  logic [FracBits:0]    fy1_q, fy2_q, fz1_q, fz2_q, fz3_q, fz4_q;

  logic signed [WV-1:0] dx_d [4];
  logic signed [WV-1:0] dy_d [2];
  logic signed [WV-1:0] dz_d;
  logic signed [WV-1:0] v;
  logic signed [WE-1:0] vs;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dx_d[k] = dot_i[2*k+1] - dot_i[2*k];
    end
    for (int j = 0; j < 2; j++) begin
      dy_d[j] = lx_q[2*j+1] - lx_q[2*j];
    end
    dz_d = ly_q[1] - ly_q[0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        px_q[k] <= WP'(signed'({1'b0, fade_i[0]})) * WP'(dx_d[k]);
        cx_q[k] <= dot_i[2*k];
        lx_q[k] <= cx_q[k] + WV'((px_q[k] + HALF) >>> FracBits);
      end
      for (int j = 0; j < 2; j++) begin
        py_q[j] <= WP'(signed'({1'b0, fy2_q})) * WP'(dy_d[j]);
        cy_q[j] <= lx_q[2*j];
        ly_q[j] <= cy_q[j] + WV'((py_q[j] + HALF) >>> FracBits);
      end
      pz_q  <= WP'(signed'({1'b0, fz4_q})) * WP'(dz_d);
      cz_q  <= ly_q[0];
      fy1_q <= fade_i[1];
      fy2_q <= fy1_q;
      fz1_q <= fade_i[2];
      fz2_q <= fz1_q;
      fz3_q <= fz2_q;
      fz4_q <= fz3_q;
    end
  end

  always_comb begin
    v  = cz_q + WV'((pz_q + HALF) >>> FracBits);
    vs = ((WE'(v) <<< SHL) + RND) >>> SHR;
    if (vs > SAT_HI) begin
      noise_o = SAT_HI[OUT_W-1:0];
    end else if (vs < SAT_LO) begin
      noise_o = SAT_LO[OUT_W-1:0];
    end else begin
      noise_o = vs[OUT_W-1:0];
    end
  end

endmodule

@@ sv/gn3_checker.sv @@
// Port-level checks for the 3D gradient noise unit, bound to its top level.
// Depends on gn3_pkg and gradient_noise_3d_unit.
module gn3_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [gn3_pkg::OUT_W-1:0]          noise_value_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(noise_value_o))
    else $error("result dropped or changed while stalled");

  a_ready_low_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> $past(out_valid_o && !out_ready_i))
    else $error("input stalled without a stalled result");

  a_ready_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && !out_valid_o |=> in_ready_o)
    else $error("input stalled while output empty");

endmodule

bind gradient_noise_3d_unit gn3_checker u_gn3_checker (.*);

@@ tb/tb_top.sv @@
// Testbench for gradient_noise_3d_unit: a directed table, then random noise and
// table-write items, each result checked against a known value from the table or
// an in-bench gradient noise predictor. Depends on gn3_pkg and the RTL of the unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gn3_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) <<< FB;
  localparam int RANDOM_ITEMS = 440;
  localparam int TIMEOUT_CYCLES = 300000;
  localparam int LONG_HOLD = 300;

  typedef logic signed [OUT_W-1:0] noise_t;

  typedef struct {
    logic               kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [PERM_AW-1:0] idx;
    logic [PERM_AW-1:0] val;
    bit                 known;
    noise_t             noise;
  } row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, kind_i, out_valid_o, out_ready_i;
  logic signed [COORD_W-1:0] coord_x_i, coord_y_i, coord_z_i;
  logic [PERM_AW-1:0] entry_index_i, entry_value_i;
  noise_t noise_value_o;

  gradient_noise_3d_unit dut (.*);

  logic [7:0] perm_mirror [PERM_DEPTH];
  noise_t expected_noise [$];
  row_t   directed [$];
  int     errors, cycles, results_seen, evals, writes;
  bit     stim_done, no_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("Timeout at %0t with %0d results pending", $time, expected_noise.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic longint mulq(longint a, longint b);
    return (a * b + ONE / 2) >>> FB;
  endfunction

  function automatic longint fade(longint t);
    longint b;
    b = mulq(t, 6 * t - 15 * ONE) + 10 * ONE;
    b = mulq(t, b);
    b = mulq(t, b);
    b = mulq(t, b);
    if (b < 0) b = 0;
    if (b > ONE) b = ONE;
    return b;
  endfunction

  function automatic longint blend(longint a0, longint a1, longint w);
    return a0 + mulq(fade(w), a1 - a0);
  endfunction

  function automatic longint grad_dot(logic [7:0] cx, logic [7:0] cy, logic [7:0] cz,
                                      longint dx, longint dy, longint dz);
    logic [7:0] h;
    int g;
    h = perm_mirror[cz];
    h = perm_mirror[8'(cy + h)];
    h = perm_mirror[8'(cx + h)];
    g = h % NUM_GRAD;
    return dx * longint'(GRAD[g][0]) + dy * longint'(GRAD[g][1])
         + dz * longint'(GRAD[g][2]);
  endfunction

  function automatic noise_t noise_at(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    logic [7:0] x0, y0, z0, x1, y1, z1;
    longint fx, fy, fz, gx, gy, gz, a, b, c, d, v;
    x0 = 8'(x >> FB); y0 = 8'(y >> FB); z0 = 8'(z >> FB);
    x1 = x0 + 8'd1; y1 = y0 + 8'd1; z1 = z0 + 8'd1;
    fx = longint'(x) & (ONE - 1);
    fy = longint'(y) & (ONE - 1);
    fz = longint'(z) & (ONE - 1);
    gx = fx - ONE; gy = fy - ONE; gz = fz - ONE;
    a = blend(grad_dot(x0, y0, z0, fx, fy, fz), grad_dot(x1, y0, z0, gx, fy, fz), fx);
    b = blend(grad_dot(x0, y1, z0, fx, gy, fz), grad_dot(x1, y1, z0, gx, gy, fz), fx);
    c = blend(grad_dot(x0, y0, z1, fx, fy, gz), grad_dot(x1, y0, z1, gx, fy, gz), fx);
    d = blend(grad_dot(x0, y1, z1, fx, gy, gz), grad_dot(x1, y1, z1, gx, gy, gz), fx);
    a = blend(a, b, fy);
    c = blend(c, d, fy);
    v = blend(a, c, fz);
    if (FB > OUT_FRAC) v = (v + (longint'(1) <<< (FB - OUT_FRAC - 1))) >>> (FB - OUT_FRAC);
    else if (FB < OUT_FRAC) v = v <<< (OUT_FRAC - FB);
    if (v > OUT_MAX) v = OUT_MAX;
    if (v < OUT_MIN) v = OUT_MIN;
    return noise_t'(v);
  endfunction

  // in-order predictor and result checker
  row_t cur;
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (kind_i == KIND_WRITE) begin
        perm_mirror[entry_index_i] = entry_value_i;
        writes++;
      end else begin
        expected_noise.push_back(cur.known ? cur.noise
                                 : noise_at(coord_x_i, coord_y_i, coord_z_i));
        evals++;
      end
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_noise.size() == 0) begin
        $display("%0t: unexpected result %0d", $time, noise_value_o);
        errors++;
      end else begin
        noise_t e;
        e = expected_noise.pop_front();
        if (noise_value_o !== e) begin
          $display("%0t: noise_value expected %0d actual %0d", $time, e, noise_value_o);
          errors++;
        end
      end
    end
  end

  // receiver: random stall per item, one long hold-off to back up the pipe
  int stall_cnt, last_seen;
  bit long_done;
  always @(negedge clk_i) begin
    if (results_seen != last_seen) begin
      last_seen = results_seen;
      if (!long_done && results_seen >= 100) begin
        stall_cnt = LONG_HOLD;
        long_done = 1;
      end else stall_cnt = no_idle ? 0 : $urandom_range(0, 6);
    end
    if (stall_cnt > 0) begin
      out_ready_i <= 1'b0;
      stall_cnt--;
    end else out_ready_i <= 1'b1;
  end

  task automatic send(row_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cur = r;
    kind_i <= r.kind;
    coord_x_i <= r.x; coord_y_i <= r.y; coord_z_i <= r.z;
    entry_index_i <= r.idx; entry_value_i <= r.val;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic row_t mk(logic k, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [7:0] i, logic [7:0] v, bit kn, noise_t n);
    row_t r;
    r.kind = k; r.x = x; r.y = y; r.z = z; r.idx = i; r.val = v;
    r.known = kn; r.noise = n;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 16 * ONE)) - 8 * ONE);
      2: return {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 3))};
      default: return {16'($urandom_range(0, 65535)), 16'hFFFF - 16'($urandom_range(0, 3))};
    endcase
  endfunction

  initial begin
    row_t r;
    for (int i = 0; i < PERM_DEPTH; i++) perm_mirror[i] = 8'(i);
    rst_ni = 1'b0; in_valid_i = 1'b0; out_ready_i = 1'b0; kind_i = KIND_EVAL;
    coord_x_i = '0; coord_y_i = '0; coord_z_i = '0;
    entry_index_i = '0; entry_value_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // lattice points give zero whatever the table holds
    directed.push_back(mk(KIND_EVAL, 0, 0, 0, 0, 0, 1, 0));
    directed.push_back(mk(KIND_EVAL, 32'h7FFF0000, 32'h7FFF0000, 32'h7FFF0000, 0, 0, 1, 0));
    directed.push_back(mk(KIND_EVAL, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 1, 0));
    directed.push_back(mk(KIND_EVAL, 32'hFFFF0000, 32'h00010000, 32'hFFFE0000,
                          8'hFF, 8'hFF, 1, 0));
    directed.push_back(mk(KIND_EVAL, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0));
    directed.push_back(mk(KIND_EVAL, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 0));
    directed.push_back(mk(KIND_EVAL, 32'h00008000, 32'h00008000, 32'h00008000, 0, 0, 0, 0));
    directed.push_back(mk(KIND_EVAL, 32'hFFFE8000, 32'h00014000, 32'hFFFFC000, 0, 0, 0, 0));
    directed.push_back(mk(KIND_EVAL, 32'h80000001, 32'h0000FFFF, 32'h80008000, 0, 0, 0, 0));
    directed.push_back(mk(KIND_WRITE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                          8'h00, 8'hFF, 0, 0));
    directed.push_back(mk(KIND_WRITE, 0, 0, 0, 8'hFF, 8'h00, 0, 0));
    directed.push_back(mk(KIND_EVAL, 32'h00008000, 32'h00008000, 32'h00008000,
                          8'hFF, 8'hFF, 0, 0));
    directed.push_back(mk(KIND_EVAL, 32'hFFFF4000, 32'hFFFF4000, 32'hFFFF4000, 0, 0, 0, 0));
    directed.push_back(mk(KIND_WRITE, 0, 0, 0, 8'h00, 8'h00, 0, 0));
    directed.push_back(mk(KIND_WRITE, 0, 0, 0, 8'hFF, 8'hFF, 0, 0));
    directed.push_back(mk(KIND_EVAL, 32'h00004000, 32'h0000C000, 32'h00002000, 0, 0, 0, 0));
    foreach (directed[i]) send(directed[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 250 && n < 320);
      if ($urandom_range(0, 99) < 15)
        r = mk(KIND_WRITE, $urandom(), $urandom(), $urandom(),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 0, 0);
      else
        r = mk(KIND_EVAL, rand_coord(), rand_coord(), rand_coord(),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 0, 0);
      send(r);
    end
    no_idle = 0;
    @(negedge clk_i) in_valid_i <= 1'b0;
    stim_done = 1;

    wait (expected_noise.size() == 0);
    repeat (30) @(posedge clk_i);
    $display("Covered %0d noise evaluations and %0d table writes, %0d results checked,",
             evals, writes, results_seen);
    $display("with random gaps on both sides and one long output hold-off.");
    if (errors == 0 && expected_noise.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
